/* hw/rtl/buddy_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy allocator package
// Constants, types and small functions shared by the allocator modules.
// ----------------------------------------------------------------------------
package buddy_pkg;

   localparam int MAX_ORDER  = 5;
   localparam int OWNER_BITS = 16;
   localparam int POOL_UNITS = 1 << MAX_ORDER;
   localparam int ADDR_W     = MAX_ORDER;
   localparam int POS_W      = MAX_ORDER + 1;
   localparam int MARK_W     = OWNER_BITS + 1;
   localparam int ORDER_W    = 3;
   localparam int SIZE_W     = 6;
   localparam int NEED_W     = SIZE_W + 1;
   localparam int COUNT_W    = 6;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [MARK_W-1:0] MARK_FREE = MARK_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_SPLIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic cfg_write;
      logic accept;
      logic advance;
      logic next_block;
      logic load_fit;
      logic split;
      logic tag;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic boundary;
      logic at_end;
      logic fit;
      logic need_split;
      logic rsp_free;
   } status_type;

   function automatic logic [POS_W-1:0] pool_end(input logic [ORDER_W-1:0] order);
      logic [ORDER_W-1:0] ord;
      ord = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;
      return POS_W'(1) << ord;
   endfunction

   function automatic logic [NEED_W-1:0] round_size(input logic [SIZE_W-1:0] size);
      logic [NEED_W-1:0] need;
      need = NEED_W'(1);
      for (int k = 0; k < NEED_W - 1; k++) begin
         if (need < NEED_W'(size)) begin
            need = need << 1;
         end
      end
      return need;
   endfunction

endpackage

/* hw/rtl/buddy_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module buddy_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/buddy_ctrl.sv */
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences the block walk, the splitting and the result transfers.
// ----------------------------------------------------------------------------
module buddy_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  csr_valid,
   input  buddy_pkg::status_type status,
   output logic                  req_stall,
   output logic                  csr_ready,
   output buddy_pkg::cmd_type    cmd
);

   buddy_pkg::state_type state_ff;
   buddy_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         buddy_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = buddy_pkg::ST_READ;
            end
         end
         buddy_pkg::ST_READ: begin
            state_in = buddy_pkg::ST_SCAN;
         end
         buddy_pkg::ST_SCAN: begin
            if (status.boundary) begin
               if (status.is_query) begin
                  state_in = buddy_pkg::ST_EMIT;
               end else if (status.fit) begin
                  state_in = buddy_pkg::ST_SPLIT;
               end else if (status.at_end) begin
                  state_in = buddy_pkg::ST_EMIT;
               end else begin
                  state_in = buddy_pkg::ST_READ;
               end
            end
         end
         buddy_pkg::ST_SPLIT: begin
            if (!status.need_split) begin
               state_in = buddy_pkg::ST_EMIT;
            end
         end
         buddy_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               if (status.is_query && !status.at_end) begin
                  state_in = buddy_pkg::ST_READ;
               end else begin
                  state_in = buddy_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = buddy_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         buddy_pkg::ST_IDLE: begin
            cmd.cfg_write = csr_valid;
            cmd.accept    = req_valid;
         end
         buddy_pkg::ST_SCAN: begin
            cmd.advance    = !status.boundary;
            cmd.load_fit   = status.boundary && !status.is_query && status.fit;
            cmd.next_block = status.boundary && !status.is_query && !status.fit
                             && !status.at_end;
         end
         buddy_pkg::ST_SPLIT: begin
            cmd.split = status.need_split;
            cmd.tag   = !status.need_split;
         end
         buddy_pkg::ST_EMIT: begin
            cmd.emit       = status.rsp_free;
            cmd.next_block = status.rsp_free && status.is_query && !status.at_end;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= buddy_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != buddy_pkg::ST_IDLE);
   assign csr_ready = (state_ff == buddy_pkg::ST_IDLE);

   a_split_stays: assert property (@(posedge clock) disable iff (reset)
      cmd.split |=> (state_ff == buddy_pkg::ST_SPLIT))
      else $error("split step left the split state");

   a_fit_splits: assert property (@(posedge clock) disable iff (reset)
      cmd.load_fit |=> (state_ff == buddy_pkg::ST_SPLIT))
      else $error("fitting block did not enter the split state");

   a_tag_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.tag |=> (state_ff == buddy_pkg::ST_EMIT))
      else $error("tagged block not followed by a result");

endmodule

/* hw/rtl/buddy_dpath.sv */
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Holds the pool marks, the walk position, the split length and the result.
// ----------------------------------------------------------------------------
module buddy_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  buddy_pkg::cmd_type                  cmd,
   input  logic [buddy_pkg::ORDER_W-1:0]       csr_pool_order,
   input  logic                                req_type,
   input  logic [buddy_pkg::OWNER_BITS-1:0]    req_owner_id,
   input  logic [buddy_pkg::SIZE_W-1:0]        req_request_size,
   input  logic                                rsp_stall,
   output buddy_pkg::status_type               status,
   output logic                                rsp_valid,
   output logic                                rsp_alloc_ok,
   output logic [buddy_pkg::ADDR_W-1:0]        rsp_block_start,
   output logic [buddy_pkg::POS_W-1:0]         rsp_block_size,
   output logic [buddy_pkg::OWNER_BITS-1:0]    rsp_block_owner,
   output logic [buddy_pkg::COUNT_W-1:0]       rsp_block_count,
   output logic                                rsp_last
);

   logic [buddy_pkg::ORDER_W-1:0]    order_ff, order_in;
   logic [buddy_pkg::POOL_UNITS-1:0] written_ff, written_in;
   logic [buddy_pkg::COUNT_W-1:0]    total_ff, total_in;
   logic                             type_ff, type_in;
   logic [buddy_pkg::OWNER_BITS-1:0] owner_ff, owner_in;
   logic [buddy_pkg::NEED_W-1:0]     need_ff, need_in;
   logic [buddy_pkg::ADDR_W-1:0]     cur_ff, cur_in;
   logic [buddy_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [buddy_pkg::POS_W-1:0]      len_ff, len_in;
   logic                             grant_ff, grant_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             ok_ff, ok_in;
   logic [buddy_pkg::ADDR_W-1:0]     start_ff, start_in;
   logic [buddy_pkg::POS_W-1:0]      size_ff, size_in;
   logic [buddy_pkg::OWNER_BITS-1:0] bown_ff, bown_in;
   logic [buddy_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                             last_ff, last_in;

   logic [buddy_pkg::POS_W-1:0]  end_w;
   logic [buddy_pkg::POS_W-1:0]  span;
   logic [buddy_pkg::POS_W-1:0]  half;
   logic [buddy_pkg::MARK_W-1:0] rd_data;
   logic [buddy_pkg::MARK_W-1:0] mark_cur;
   logic [buddy_pkg::MARK_W-1:0] mark_owner;
   logic [buddy_pkg::ADDR_W-1:0] split_addr;
   logic                         wr_en;
   logic [buddy_pkg::ADDR_W-1:0] wr_addr;
   logic [buddy_pkg::MARK_W-1:0] wr_data;
   logic                         rsp_free;

   assign end_w      = buddy_pkg::pool_end(order_ff);
   assign span       = pos_ff - buddy_pkg::POS_W'(cur_ff);
   assign half       = len_ff >> 1;
   assign mark_cur   = written_ff[cur_ff] ? rd_data : buddy_pkg::MARK_FREE;
   assign mark_owner = mark_cur - buddy_pkg::MARK_FREE;
   assign split_addr = cur_ff + half[buddy_pkg::ADDR_W-1:0];
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign wr_en   = cmd.split || cmd.tag;
   assign wr_addr = cmd.tag ? cur_ff : split_addr;
   assign wr_data = cmd.tag ? (buddy_pkg::MARK_W'(owner_ff) + buddy_pkg::MARK_FREE)
                            : buddy_pkg::MARK_FREE;

   buddy_ram #(
      .WIDTH (buddy_pkg::MARK_W),
      .DEPTH (buddy_pkg::POOL_UNITS)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      status.is_query   = (type_ff == buddy_pkg::REQ_QUERY);
      status.at_end     = (pos_ff == end_w);
      status.boundary   = status.at_end || written_ff[pos_ff[buddy_pkg::ADDR_W-1:0]];
      status.fit        = (mark_cur == buddy_pkg::MARK_FREE)
                          && (buddy_pkg::NEED_W'(span) >= need_ff);
      status.need_split = (buddy_pkg::NEED_W'(len_ff) > need_ff);
      status.rsp_free   = rsp_free;
   end

   always_comb begin
      order_in     = order_ff;
      written_in   = written_ff;
      total_in     = total_ff;
      type_in      = type_ff;
      owner_in     = owner_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      grant_in     = grant_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ok_in        = ok_ff;
      start_in     = start_ff;
      size_in      = size_ff;
      bown_in      = bown_ff;
      count_in     = count_ff;
      last_in      = last_ff;

      if (cmd.cfg_write) begin
         order_in   = csr_pool_order;
         written_in = '0;
         total_in   = buddy_pkg::COUNT_W'(1);
      end
      if (cmd.accept) begin
         type_in  = req_type;
         owner_in = req_owner_id;
         need_in  = buddy_pkg::round_size(req_request_size);
         cur_in   = '0;
         pos_in   = buddy_pkg::POS_W'(1);
         grant_in = 1'b0;
      end
      if (cmd.advance) begin
         pos_in = pos_ff + buddy_pkg::POS_W'(1);
      end
      if (cmd.next_block) begin
         cur_in = pos_ff[buddy_pkg::ADDR_W-1:0];
         pos_in = pos_ff + buddy_pkg::POS_W'(1);
      end
      if (cmd.load_fit) begin
         len_in = span;
      end
      if (cmd.split) begin
         len_in                = half;
         written_in[split_addr] = 1'b1;
         total_in              = total_ff + buddy_pkg::COUNT_W'(1);
      end
      if (cmd.tag) begin
         written_in[cur_ff] = 1'b1;
         grant_in           = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         count_in     = total_ff;
         if (type_ff == buddy_pkg::REQ_QUERY) begin
            ok_in    = 1'b0;
            start_in = cur_ff;
            size_in  = span;
            bown_in  = mark_owner[buddy_pkg::OWNER_BITS-1:0];
            last_in  = status.at_end;
         end else if (grant_ff) begin
            ok_in    = 1'b1;
            start_in = cur_ff;
            size_in  = len_ff;
            bown_in  = owner_ff;
            last_in  = 1'b1;
         end else begin
            ok_in    = 1'b0;
            start_in = '0;
            size_in  = '0;
            bown_in  = '0;
            last_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= buddy_pkg::ORDER_W'(buddy_pkg::MAX_ORDER);
         written_ff   <= '0;
         total_ff     <= buddy_pkg::COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         order_ff     <= order_in;
         written_ff   <= written_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff  <= type_in;
      owner_ff <= owner_in;
      need_ff  <= need_in;
      cur_ff   <= cur_in;
      pos_ff   <= pos_in;
      len_ff   <= len_in;
      grant_ff <= grant_in;
      ok_ff    <= ok_in;
      start_ff <= start_in;
      size_ff  <= size_in;
      bown_ff  <= bown_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alloc_ok    = ok_ff;
   assign rsp_block_start = start_ff;
   assign rsp_block_size  = size_ff;
   assign rsp_block_owner = bown_ff;
   assign rsp_block_count = count_ff;
   assign rsp_last        = last_ff;

   a_split_inside: assert property (@(posedge clock) disable iff (reset)
      cmd.split |-> ((buddy_pkg::POS_W'(cur_ff) + half) < end_w))
      else $error("split mark written beyond the pool end");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten before transfer");

   a_walk_inside: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (pos_ff < end_w))
      else $error("walk ran past the pool end");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) && (total_ff <= buddy_pkg::COUNT_W'(buddy_pkg::POOL_UNITS)))
      else $error("block count out of range");

endmodule

/* hw/rtl/buddy_allocator.sv */
// ----------------------------------------------------------------------------
// Buddy allocator
// Allocate-only buddy allocator over a pool of up to 32 units, with a query
// that lists every block in address order.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req       in         req_valid/req_stall  req_type, req_owner_id, req_request_size
//  rsp       out        rsp_valid/rsp_stall  rsp_alloc_ok .. rsp_last
//  csr       in         csr_valid/csr_ready  csr_pool_order
//
// A request walks the pool one unit at a time, with a separate read step for the
// mark of each block visited; a split step halves the fitting block until it
// matches the rounded size. An allocate stops at the first free block that fits
// or at the pool end; a query walks the whole pool and gives one result per block.
// Each result waits in an output register; a stall only holds the walk when
// the next result is ready. Reset restores a pool of order 5 with one free
// block, and a csr transfer does the same for the order written.
// ----------------------------------------------------------------------------
module buddy_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [buddy_pkg::OWNER_BITS-1:0]    req_owner_id,
   input  logic [buddy_pkg::SIZE_W-1:0]        req_request_size,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_alloc_ok,
   output logic [buddy_pkg::ADDR_W-1:0]        rsp_block_start,
   output logic [buddy_pkg::POS_W-1:0]         rsp_block_size,
   output logic [buddy_pkg::OWNER_BITS-1:0]    rsp_block_owner,
   output logic [buddy_pkg::COUNT_W-1:0]       rsp_block_count,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [buddy_pkg::ORDER_W-1:0]       csr_pool_order
);

   buddy_pkg::cmd_type    cmd;
   buddy_pkg::status_type status;

   buddy_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_valid (csr_valid),
      .status    (status),
      .req_stall (req_stall),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   buddy_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_pool_order   (csr_pool_order),
      .req_type         (req_type),
      .req_owner_id     (req_owner_id),
      .req_request_size (req_request_size),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_alloc_ok     (rsp_alloc_ok),
      .rsp_block_start  (rsp_block_start),
      .rsp_block_size   (rsp_block_size),
      .rsp_block_owner  (rsp_block_owner),
      .rsp_block_count  (rsp_block_count),
      .rsp_last         (rsp_last)
   );

endmodule
